### hw/rtl/kpd_pkg.sv
// ----------------------------------------------------------------------------
// kpd_pkg
// shared widths, codes, register defaults and types of the key event detector
// ----------------------------------------------------------------------------
`default_nettype none

package kpd_pkg;

    localparam int KEY_FIELD_W  = 5;
    localparam int KEY_IDX_W    = 3;
    localparam int EV_W         = 3;
    localparam int CNT_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int NUM_KEYS_DEF = 5;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 2'd2;

    localparam logic [CNT_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [CNT_W-1:0] LONG_RST     = 16'd1000;
    localparam logic [CNT_W-1:0] REPEAT_RST   = 16'd100;

    typedef enum logic [1:0] {
        PH_WAIT     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_LONG     = 2'd2,
        PH_REPEAT   = 2'd3
    } t_phase;

    typedef enum logic [EV_W-1:0] {
        EV_PRESSED       = 3'd0,
        EV_SHORT_RELEASE = 3'd1,
        EV_LONG_PRESS    = 3'd2,
        EV_REPEAT        = 3'd3,
        EV_LONG_RELEASE  = 3'd4
    } t_event;

endpackage

`default_nettype wire

### hw/rtl/kpd_if.sv
// ----------------------------------------------------------------------------
// kpd_if
// valid/ready channels of the key event detector: scan ticks, events, config
// ----------------------------------------------------------------------------
`default_nettype none

interface kpd_tick_if import kpd_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [KEY_FIELD_W-1:0] irq_flags;
    logic [KEY_FIELD_W-1:0] key_pressed;

    modport source (output valid, output irq_flags, output key_pressed, input ready);
    modport sink   (input valid, input irq_flags, input key_pressed, output ready);
endinterface

interface kpd_event_if import kpd_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [KEY_IDX_W-1:0] key_index;
    logic [EV_W-1:0]      event_kind;
    logic                 last;

    modport source (output valid, output key_index, output event_kind, output last,
                    input ready);
    modport sink   (input valid, input key_index, input event_kind, input last,
                    output ready);
endinterface

interface kpd_cfg_if import kpd_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/key_press_event_detector.sv
// ----------------------------------------------------------------------------
// key_press_event_detector
// per-key debounce, long press and repeat detection on scan ticks
// ----------------------------------------------------------------------------
// path: tick events go through the queue, the back's bundle register and the output register
// throughput: one tick per cycle while the bundle queue has room; events
//   leave one per cycle while the output register is not stalled
// reset: synchronous, active low; all keys in wait with counts and pending
//   cleared, tick registers back to 20 / 1000 / 100, queue and output empty
// ----------------------------------------------------------------------------
`default_nettype none

module key_press_event_detector import kpd_pkg::*; #(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    kpd_tick_if.sink      i_tick,
    kpd_cfg_if.sink       i_cfg,
    kpd_event_if.source   o_event
);

    localparam int BUNDLE_W = NUM_KEYS * (1 + EV_W);

    logic                          w_tick_ready;
    logic                          w_q_full;
    logic                          w_q_push;
    logic                          w_q_pop;
    logic                          w_q_valid;
    logic [NUM_KEYS-1:0]           w_ev_mask;
    logic [NUM_KEYS-1:0][EV_W-1:0] w_ev_kind;
    logic [BUNDLE_W-1:0]           w_q_wdata;
    logic [BUNDLE_W-1:0]           w_q_rdata;
    logic [NUM_KEYS-1:0]           w_q_mask;
    logic [NUM_KEYS-1:0][EV_W-1:0] w_q_kind;

    assign i_tick.ready = w_tick_ready;
    assign i_cfg.ready  = 1'b1;

    kpd_front #(
        .NUM_KEYS (NUM_KEYS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick_valid  (i_tick.valid),
        .o_tick_ready  (w_tick_ready),
        .i_irq_flags   (i_tick.irq_flags),
        .i_key_pressed (i_tick.key_pressed),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_ev_mask     (w_ev_mask),
        .o_ev_kind     (w_ev_kind)
    );

    assign w_q_wdata = {w_ev_mask, w_ev_kind};
    assign {w_q_mask, w_q_kind} = w_q_rdata;

    kpd_queue #(
        .W     (BUNDLE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_data  (w_q_rdata)
    );

    kpd_back #(
        .NUM_KEYS (NUM_KEYS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_mask     (w_q_mask),
        .i_q_kind     (w_q_kind),
        .o_q_pop      (w_q_pop),
        .o_valid      (o_event.valid),
        .i_ready      (o_event.ready),
        .o_key_index  (o_event.key_index),
        .o_event_kind (o_event.event_kind),
        .o_last       (o_event.last)
    );

endmodule

`default_nettype wire

### hw/rtl/kpd_front.sv
// ----------------------------------------------------------------------------
// kpd_front
// config registers and per-key debounce / long press / repeat machines;
// pushes the events of one tick into the queue as a bundle
// ----------------------------------------------------------------------------
`default_nettype none

module kpd_front import kpd_pkg::*; #(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_tick_valid,
    output logic                                o_tick_ready,
    input  wire logic [KEY_FIELD_W-1:0]         i_irq_flags,
    input  wire logic [KEY_FIELD_W-1:0]         i_key_pressed,
    input  wire logic                           i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]           i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]          i_cfg_data,
    input  wire logic                           i_q_full,
    output logic                                o_q_push,
    output logic [NUM_KEYS-1:0]                 o_ev_mask,
    output logic [NUM_KEYS-1:0][EV_W-1:0]       o_ev_kind
);

    logic [CNT_W-1:0] r_debounce;
    logic [CNT_W-1:0] r_long;
    logic [CNT_W-1:0] r_repeat;

    t_phase           r_phase   [NUM_KEYS];
    t_phase           n_phase   [NUM_KEYS];
    logic [CNT_W-1:0] r_cnt     [NUM_KEYS];
    logic [CNT_W-1:0] n_cnt     [NUM_KEYS];
    logic [CNT_W-1:0] w_inc     [NUM_KEYS];
    logic [CNT_W-1:0] w_target  [NUM_KEYS];
    logic [NUM_KEYS-1:0] r_pending;
    logic [NUM_KEYS-1:0] n_pending;
    logic [NUM_KEYS-1:0] w_pend;

    logic [NUM_KEYS+KEY_FIELD_W-1:0] w_irq_ext;
    logic [NUM_KEYS+KEY_FIELD_W-1:0] w_lvl_ext;
    logic [NUM_KEYS-1:0]             w_irq;
    logic [NUM_KEYS-1:0]             w_lvl;
    logic                            w_accept;

    // key bits beyond the input field stay released and never pending
    assign w_irq_ext = {{NUM_KEYS{1'b0}}, i_irq_flags};
    assign w_lvl_ext = {{NUM_KEYS{1'b0}}, i_key_pressed};
    assign w_irq     = w_irq_ext[NUM_KEYS-1:0];
    assign w_lvl     = w_lvl_ext[NUM_KEYS-1:0];

    assign o_tick_ready = !i_q_full;
    assign w_accept     = i_tick_valid && o_tick_ready;
    assign o_q_push     = w_accept && (|o_ev_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RST;
            r_long     <= LONG_RST;
            r_repeat   <= REPEAT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                CFG_LONG:     r_long     <= i_cfg_data;
                CFG_REPEAT:   r_repeat   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_phase[k] <= PH_WAIT;
                r_cnt[k]   <= '0;
            end
        end else if (w_accept) begin
            r_pending <= n_pending;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_phase[k] <= n_phase[k];
                r_cnt[k]   <= n_cnt[k];
            end
        end
    end

    // one counter per key: each phase count is zero outside its own phase
    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            w_pend[k]    = r_pending[k] | w_irq[k];
            n_pending[k] = w_pend[k];
            n_phase[k]   = r_phase[k];
            n_cnt[k]     = r_cnt[k];
            w_inc[k]     = r_cnt[k] + CNT_W'(1);
            o_ev_mask[k] = 1'b0;
            o_ev_kind[k] = EV_PRESSED;
            unique case (r_phase[k])
                PH_DEBOUNCE: w_target[k] = r_debounce;
                PH_LONG:     w_target[k] = r_long;
                default:     w_target[k] = r_repeat;
            endcase
            if (w_pend[k] || (r_phase[k] != PH_WAIT)) begin
                unique case (r_phase[k])
                    PH_WAIT: begin
                        if (w_lvl[k]) begin
                            n_phase[k] = PH_DEBOUNCE;
                        end else begin
                            n_pending[k] = 1'b0;
                        end
                    end
                    PH_DEBOUNCE: begin
                        if (w_lvl[k]) begin
                            if (w_inc[k] == w_target[k]) begin
                                n_cnt[k]     = '0;
                                n_phase[k]   = PH_LONG;
                                o_ev_mask[k] = 1'b1;
                                o_ev_kind[k] = EV_PRESSED;
                            end else begin
                                n_cnt[k] = w_inc[k];
                            end
                        end else begin
                            n_cnt[k]     = '0;
                            n_phase[k]   = PH_WAIT;
                            n_pending[k] = 1'b0;
                        end
                    end
                    PH_LONG: begin
                        if (w_lvl[k]) begin
                            if (w_inc[k] == w_target[k]) begin
                                n_cnt[k]     = '0;
                                n_phase[k]   = PH_REPEAT;
                                o_ev_mask[k] = 1'b1;
                                o_ev_kind[k] = EV_LONG_PRESS;
                            end else begin
                                n_cnt[k] = w_inc[k];
                            end
                        end else begin
                            n_cnt[k]     = '0;
                            n_phase[k]   = PH_WAIT;
                            n_pending[k] = 1'b0;
                            o_ev_mask[k] = 1'b1;
                            o_ev_kind[k] = EV_SHORT_RELEASE;
                        end
                    end
                    default: begin
                        if (w_lvl[k]) begin
                            if (w_inc[k] == w_target[k]) begin
                                n_cnt[k]     = '0;
                                o_ev_mask[k] = 1'b1;
                                o_ev_kind[k] = EV_REPEAT;
                            end else begin
                                n_cnt[k] = w_inc[k];
                            end
                        end else begin
                            n_cnt[k]     = '0;
                            n_phase[k]   = PH_WAIT;
                            n_pending[k] = 1'b0;
                            o_ev_mask[k] = 1'b1;
                            o_ev_kind[k] = EV_LONG_RELEASE;
                        end
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/kpd_queue.sv
// ----------------------------------------------------------------------------
// kpd_queue
// short fifo of event bundles between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module kpd_queue import kpd_pkg::*; #(
    parameter int W     = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic              o_valid,
    output logic              o_full,
    output logic [W-1:0]      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    logic [W-1:0]      r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_QW'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_QW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_QW'(1);
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/kpd_back.sv
// ----------------------------------------------------------------------------
// kpd_back
// takes bundles from the queue and sends their events in key order,
// one per cycle while the output is not stalled, through an output register
// ----------------------------------------------------------------------------
`default_nettype none

module kpd_back import kpd_pkg::*; #(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  wire logic [NUM_KEYS-1:0]           i_q_mask,
    input  wire logic [NUM_KEYS-1:0][EV_W-1:0] i_q_kind,
    output logic                               o_q_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [KEY_IDX_W-1:0]               o_key_index,
    output logic [EV_W-1:0]                    o_event_kind,
    output logic                               o_last
);

    localparam int KIDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic                          r_busy;
    logic [NUM_KEYS-1:0]           r_mask;
    logic [NUM_KEYS-1:0][EV_W-1:0] r_kind;
    logic                          r_out_valid;
    logic [KEY_IDX_W-1:0]          r_key_index;
    logic [EV_W-1:0]               r_event_kind;
    logic                          r_last;

    logic [KIDX_W-1:0]             w_sel;
    logic [NUM_KEYS-1:0]           w_rem;
    logic                          w_emit;
    logic                          w_done;
    logic [KIDX_W+KEY_IDX_W-1:0]   w_sel_ext;

    always_comb begin
        w_sel = '0;
        for (int k = NUM_KEYS - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                w_sel = KIDX_W'(k);
            end
        end
        for (int k = 0; k < NUM_KEYS; k++) begin
            w_rem[k] = r_mask[k] && (KIDX_W'(k) != w_sel);
        end
    end

    assign w_sel_ext = {{KEY_IDX_W{1'b0}}, w_sel};
    assign w_emit    = r_busy && (!r_out_valid || i_ready);
    assign w_done    = w_emit && (w_rem == '0);
    assign o_q_pop   = i_q_valid && (!r_busy || w_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_mask <= i_q_mask;
            r_kind <= i_q_kind;
        end else if (w_emit) begin
            r_mask <= w_rem;
        end
        if (w_emit) begin
            r_key_index  <= w_sel_ext[KEY_IDX_W-1:0];
            r_event_kind <= r_kind[w_sel];
            r_last       <= (w_rem == '0);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_key_index  = r_key_index;
    assign o_event_kind = r_event_kind;
    assign o_last       = r_last;

endmodule

`default_nettype wire
